[rtl/core/emii_pkg.sv]
// Shared widths, register indexes and the line-buffer word for the edge-masked integral image.
package emii_pkg;

    localparam int GRAD_W = 16;
    localparam int SUM_W  = 36;
    localparam int CNT_W  = 21;
    localparam int CFG_W  = 11;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // One column of the previous row's totals.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } line_word_t;

endpackage

[rtl/core/emii_line_buf.sv]
// Line buffer of the previous row's totals with same-address write forwarding.
module emii_line_buf #(
    parameter int DEPTH = emii_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  emii_pkg::line_word_t     wr_data,
    output emii_pkg::line_word_t     rd_data
);

    emii_pkg::line_word_t mem [DEPTH];
    emii_pkg::line_word_t mem_q_reg;
    emii_pkg::line_word_t byp_data_reg;
    logic                 byp_valid_reg;
    logic                 byp_valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // A read that meets a write to the same column in the same cycle takes the new data.
    always_comb
    begin
        byp_valid_next = byp_valid_reg;
        if (rd_en)
        begin
            byp_valid_next = wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
        end
    end

    assign rd_data = byp_valid_reg ? byp_data_reg : mem_q_reg;

endmodule

[rtl/core/edge_masked_integral_image.sv]
// Top level of the streaming edge-masked integral image (summed-area table) block.
// Pixels enter in raster order on the pixel channel (pixel_valid / pixel_stall) with an
// edge flag and a 12.4 gradient. For every pixel one result leaves on the result channel
// (result_valid / result_stall): the masked gradient sum and edge count over the rectangle
// from the frame origin to that pixel, and frame_end on the last pixel of the frame.
// image_width and image_height are written over the cfg channel (index 0 and 1); cfg_ready
// is always high. Values outside 1..MAX_WIDTH or 1..MAX_HEIGHT are saturated into range.
// A result passes through the add stage and then the output register: the line-buffer read
// at the request's column is issued in the accepting cycle, and the add stage adds the row
// sum and writes the new total back into the line buffer and the output register. A new
// request is accepted every cycle while pixel_stall is low; the single line-buffer read
// per pixel sets that rate. A request whose column was just written by the previous
// request (width one) gets the new total forwarded. Reset clears the position, the row
// sums and the pipeline valids and restores both dimensions to 1024; the line buffer is
// not cleared since row 0 ignores what it reads from it.
// When the receiver stalls, the output register holds its result and one more request is
// taken into the add stage; pixel_stall rises only while both are full.
module edge_masked_integral_image #(
    parameter int MAX_WIDTH  = emii_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = emii_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic                            edge_flag,
    input  logic [emii_pkg::GRAD_W-1:0]     gradient,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [emii_pkg::SUM_W-1:0]      masked_sum,
    output logic [emii_pkg::CNT_W-1:0]      edge_count,
    output logic                            frame_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [emii_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [emii_pkg::CFG_W-1:0]      cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int RSUM_W = COL_W + emii_pkg::GRAD_W;
    localparam int RCNT_W = COL_W + 1;
    localparam int DW0    = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
    localparam int DIM_W  = (DW0 > emii_pkg::CFG_W) ? DW0 : emii_pkg::CFG_W;

    // Configuration registers.
    logic [emii_pkg::CFG_W-1:0] width_reg;
    logic [emii_pkg::CFG_W-1:0] height_reg;

    // Raster position and running row sums of the next request.
    logic [COL_W-1:0]  col_reg,      col_next;
    logic [ROW_W-1:0]  row_reg,      row_next;
    logic [RSUM_W-1:0] row_sum_reg,  row_sum_next;
    logic [RCNT_W-1:0] row_cnt_reg,  row_cnt_next;

    // Add stage.
    logic              s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]  s1_col_reg;
    logic [RSUM_W-1:0] s1_row_sum_reg;
    logic [RCNT_W-1:0] s1_row_cnt_reg;
    logic              s1_above_reg;
    logic              s1_end_reg;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [emii_pkg::SUM_W-1:0]  out_sum_reg;
    logic [emii_pkg::CNT_W-1:0]  out_cnt_reg;
    logic                        out_end_reg;

    logic                 pixel_accept;
    logic                 s1_adv;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic                 last_col;
    logic                 last_row;
    logic [RSUM_W-1:0]    sum_base;
    logic [RCNT_W-1:0]    cnt_base;
    emii_pkg::line_word_t above_word;
    emii_pkg::line_word_t up_word;
    emii_pkg::line_word_t total_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= emii_pkg::DIM_RESET;
            height_reg <= emii_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (emii_pkg::reg_index_t'(cfg_index))
                emii_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                emii_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the add stage moves on when the output register is free or being drained.
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign pixel_stall  = s1_valid_reg && !s1_adv;
    assign pixel_accept = pixel_valid && !pixel_stall;

    // Saturate the dimensions into their legal ranges; zero behaves as one.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DIM_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = DIM_W'(height_reg);
        end
    end

    // Position at or beyond the last column (or row) ends the row (or frame) there.
    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;

    always_comb
    begin
        sum_base = (col_reg == '0) ? '0 : row_sum_reg;
        cnt_base = (col_reg == '0) ? '0 : row_cnt_reg;

        row_sum_next = row_sum_reg;
        row_cnt_next = row_cnt_reg;
        col_next     = col_reg;
        row_next     = row_reg;

        if (pixel_accept)
        begin
            row_sum_next = edge_flag ? sum_base + RSUM_W'(gradient) : sum_base;
            row_cnt_next = edge_flag ? cnt_base + RCNT_W'(1) : cnt_base;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_sum_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            row_sum_reg <= row_sum_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // The add stage loads alongside the line-buffer read.
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_col_reg     <= col_reg;
            s1_row_sum_reg <= row_sum_next;
            s1_row_cnt_reg <= row_cnt_next;
            s1_above_reg   <= (row_reg != '0);
            s1_end_reg     <= last_col && last_row;
        end
    end

    emii_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pixel_accept),
        .rd_addr (col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (total_word),
        .rd_data (above_word)
    );

    // Row 0 sees zero above; the new total goes back into the line buffer.
    always_comb
    begin
        up_word          = s1_above_reg ? above_word : '0;
        total_word.sum   = up_word.sum + emii_pkg::SUM_W'(s1_row_sum_reg);
        total_word.count = up_word.count + emii_pkg::CNT_W'(s1_row_cnt_reg);
    end

    always_comb
    begin
        s1_valid_next  = pixel_accept || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_sum_reg <= total_word.sum;
            out_cnt_reg <= total_word.count;
            out_end_reg <= s1_end_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign masked_sum   = out_sum_reg;
    assign edge_count   = out_cnt_reg;
    assign frame_end    = out_end_reg;

endmodule

[rtl/core/emii_checker.sv]
// Port-level checker for the edge-masked integral image, bound to the top level.
module emii_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_valid,
    input logic                        pixel_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [emii_pkg::SUM_W-1:0]  masked_sum,
    input logic [emii_pkg::CNT_W-1:0]  edge_count,
    input logic                        frame_end,
    input logic                        cfg_ready
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = pixel_valid && !pixel_stall;
    assign out_acc = result_valid && !result_stall;

    // Requests accepted whose results are not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(masked_sum)
            && $stable(edge_count) && $stable(frame_end))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("input stalled while output was free");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result without an outstanding request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more requests in flight than pipeline holds");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind edge_masked_integral_image emii_checker u_emii_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .masked_sum   (masked_sum),
    .edge_count   (edge_count),
    .frame_end    (frame_end),
    .cfg_ready    (cfg_ready)
);

[tb/tb_edge_masked_integral_image.sv]
// Self-checking testbench for the edge-masked integral image block.
`timescale 1ns / 1ps

module tb_edge_masked_integral_image;

    // The block is built with its default line-buffer depth and frame height.
    localparam int MAX_W = emii_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H = emii_pkg::MAX_HEIGHT_DEF;

    // Idle share per side, in percent, and the number of random pixels to send.
    localparam int IDLE_PCT      = 22;
    localparam int RANDOM_PIXELS = 720;

    // Cycles without any accepted request before the run is declared hung. The slowest
    // legal gap is a short random idle run or a register write, far below this.
    localparam int WATCHDOG_LIMIT = 5000;

    // One pixel request as the sender holds it before it goes onto the ports.
    typedef struct packed {
        logic                        edge_bit;
        logic [emii_pkg::GRAD_W-1:0] grad;
    } pixel_req_t;

    // One summed-area result as the block should deliver it.
    typedef struct packed {
        logic [emii_pkg::SUM_W-1:0] sum;
        logic [emii_pkg::CNT_W-1:0] count;
        logic                       last;
    } area_total_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           pixel_valid  = 1'b0;
    logic                           pixel_stall;
    logic                           edge_flag    = 1'b0;
    logic [emii_pkg::GRAD_W-1:0]    gradient     = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [emii_pkg::SUM_W-1:0]     masked_sum;
    logic [emii_pkg::CNT_W-1:0]     edge_count;
    logic                           frame_end;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [emii_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [emii_pkg::CFG_W-1:0]     cfg_data     = '0;

    // While this is set neither side idles, giving one long back-to-back stretch.
    logic steady = 1'b0;

    edge_masked_integral_image i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .edge_flag    (edge_flag),
        .gradient     (gradient),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .masked_sum   (masked_sum),
        .edge_count   (edge_count),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Pixels waiting to be sent, and the totals the block owes us in order.
    pixel_req_t  pending_pixels[$];
    area_total_t expected_totals[$];
    pixel_req_t  next_pixel;

    // Our own copy of the integral image state: the previous row's totals per column,
    // the running sums of the current row, the raster position and both dimensions.
    logic [emii_pkg::SUM_W-1:0] prev_row_sum [MAX_W];
    logic [emii_pkg::CNT_W-1:0] prev_row_count [MAX_W];
    logic [emii_pkg::SUM_W-1:0] run_sum    = '0;
    logic [emii_pkg::CNT_W-1:0] run_count  = '0;
    int                         pos_col    = 0;
    int                         pos_row    = 0;
    logic [emii_pkg::CFG_W-1:0] cur_width  = emii_pkg::DIM_RESET;
    logic [emii_pkg::CFG_W-1:0] cur_height = emii_pkg::DIM_RESET;

    int mismatch_count  = 0;
    int pixels_accepted = 0;
    int frames_seen     = 0;
    int reg_writes      = 0;
    int idle_cycles     = 0;

    // The block saturates a dimension into 1..limit; a zero register acts as one.
    function automatic int eff_dim(input logic [emii_pkg::CFG_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    // Advance the integral image by one pixel and queue the totals it must produce.
    // The first row of a frame sees zero above; every other row adds the column's total
    // from the row before. A position at or past the last column or row ends it, which
    // is what makes a dimension that shrinks in the middle of a frame take effect at once.
    task automatic integrate_pixel(input logic is_edge,
                                   input logic [emii_pkg::GRAD_W-1:0] grad);
        area_total_t                tot;
        int                         w;
        int                         h;
        int                         c;
        logic [emii_pkg::SUM_W-1:0] up_sum;
        logic [emii_pkg::CNT_W-1:0] up_count;
        w = eff_dim(cur_width, MAX_W);
        h = eff_dim(cur_height, MAX_H);
        c = (pos_col >= MAX_W) ? MAX_W - 1 : pos_col;
        if (c == 0)
        begin
            run_sum   = '0;
            run_count = '0;
        end
        if (is_edge)
        begin
            run_sum   = run_sum + grad;
            run_count = run_count + 1'b1;
        end
        up_sum   = (pos_row != 0) ? prev_row_sum[c] : '0;
        up_count = (pos_row != 0) ? prev_row_count[c] : '0;
        tot.sum   = up_sum + run_sum;
        tot.count = up_count + run_count;
        tot.last  = (c + 1 >= w) && (pos_row + 1 >= h);
        prev_row_sum[c]   = tot.sum;
        prev_row_count[c] = tot.count;
        expected_totals.insert(expected_totals.size(), tot);
        if (c + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
        end
        else
        begin
            pos_col = c + 1;
        end
    endtask

    // Pixels still needed to reach the end of the current frame from our position.
    function automatic int pixels_to_frame_end();
        int w;
        int h;
        int in_row;
        w = eff_dim(cur_width, MAX_W);
        h = eff_dim(cur_height, MAX_H);
        in_row = (pos_col + 1 >= w) ? 1 : w - pos_col;
        if (pos_row + 1 >= h)
            return in_row;
        return in_row + (h - pos_row - 1) * w;
    endfunction

    // Sender. A request is taken at an edge where valid is high and stall is low; only
    // then, or while idle, may the next pixel or an idle cycle be put on the ports, so a
    // stalled payload never moves. Prediction runs at the moment of acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            edge_flag   <= 1'b0;
            gradient    <= '0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                integrate_pixel(edge_flag, gradient);
                pixels_accepted++;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (pending_pixels.size() != 0
                    && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_pixel = pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                    edge_flag   <= next_pixel.edge_bit;
                    gradient    <= next_pixel.grad;
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Compare one delivered result, field by field, against the oldest expectation.
    task automatic check_total();
        area_total_t want;
        if (expected_totals.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected result sum=%0d count=%0d frame_end=%0b",
                         $realtime, masked_sum, edge_count, frame_end);
            return;
        end
        want = expected_totals.pop_front();
        if (want.last)
            frames_seen++;
        if (masked_sum !== want.sum || edge_count !== want.count || frame_end !== want.last)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: mismatch sum %0d/%0d count %0d/%0d frame_end %0b/%0b (exp/act)",
                         $realtime, want.sum, masked_sum, want.count, edge_count,
                         want.last, frame_end);
        end
    endtask

    // Receiver. Results are checked on acceptance; stall is drawn fresh every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_total();
            result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: any accepted request on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no request accepted for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_pixel(input logic is_edge, input logic [emii_pkg::GRAD_W-1:0] grad);
        pixel_req_t p;
        p.edge_bit = is_edge;
        p.grad     = grad;
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    // Random pixel content, with the gradient extremes drawn more often than chance.
    task automatic push_random_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(7))
                0:       push_pixel(1'($urandom_range(1)), '1);
                1:       push_pixel(1'($urandom_range(1)), '0);
                default: push_pixel(1'($urandom_range(1)),
                                    emii_pkg::GRAD_W'($urandom_range(16'hFFFF)));
            endcase
        end
    endtask

    // Wait until every pixel has been sent and every owed total has come back. Every
    // pixel yields a result, so the pipeline is empty at that point.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_pixels.size() != 0 || pixel_valid || expected_totals.size() != 0);
    endtask

    // One register write request; the predictor takes the value once it is accepted.
    task automatic write_register(input emii_pkg::reg_index_t idx,
                                  input logic [emii_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == emii_pkg::REG_IMAGE_WIDTH)
            cur_width = value;
        else
            cur_height = value;
        reg_writes++;
    endtask

    task automatic finish_frame();
        push_random_pixels(pixels_to_frame_end());
        wait_drained();
    endtask

    // Set both dimensions at a frame boundary and send whole frames of random pixels.
    task automatic run_frames(input logic [emii_pkg::CFG_W-1:0] w_reg,
                              input logic [emii_pkg::CFG_W-1:0] h_reg,
                              input int nframes);
        write_register(emii_pkg::REG_IMAGE_WIDTH, w_reg);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, h_reg);
        push_random_pixels(nframes * eff_dim(w_reg, MAX_W) * eff_dim(h_reg, MAX_H));
        wait_drained();
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        int nframes;
        int random_pixels;
        int steady_pixels;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // A 3x3 frame by hand: gradient extremes with and without the edge flag, the first
        // row reading zero from above and the later rows adding the column totals.
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd3);
        push_pixel(1'b1, 16'hFFFF);
        push_pixel(1'b1, 16'h0000);
        push_pixel(1'b0, 16'hFFFF);
        push_pixel(1'b1, 16'h0001);
        push_pixel(1'b0, 16'h0000);
        push_pixel(1'b1, 16'hFFFF);
        push_pixel(1'b1, 16'h8000);
        push_pixel(1'b0, 16'h7FFF);
        push_pixel(1'b1, 16'hFFFF);
        wait_drained();

        // A single column: every pixel reads the total its predecessor just wrote.
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd1);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd3);
        push_pixel(1'b1, 16'hFFFF);
        push_pixel(1'b0, 16'hFFFF);
        push_pixel(1'b1, 16'hFFFF);
        wait_drained();

        // Both dimensions shrink in the middle of a frame: the position is already past
        // the new last column and last row, so the very next pixel ends the frame.
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd6);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd4);
        push_random_pixels(8);
        wait_drained();
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd2);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd2);
        finish_frame();

        // The height grows in the middle of a frame, so the frame runs on by one more row.
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd2);
        push_random_pixels(4);
        wait_drained();
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd3);
        finish_frame();

        // Extreme settings: a zero width or height acts as one.
        run_frames(11'd0, 11'd5, 1);
        run_frames(11'd7, 11'd0, 1);

        // An all-ones width saturates high, so a long first row runs on without ending;
        // shrinking the width then ends the frame at the next pixel.
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'h7FF);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd1);
        push_random_pixels(20);
        wait_drained();
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd2);
        finish_frame();

        // The same for an all-ones height on a single column.
        write_register(emii_pkg::REG_IMAGE_WIDTH, 11'd1);
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
        push_random_pixels(20);
        wait_drained();
        write_register(emii_pkg::REG_IMAGE_HEIGHT, 11'd1);
        finish_frame();

        // Random part: small frames of random shape, a few frames per setting, with one
        // stretch where neither side idles.
        random_pixels = 0;
        steady_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            steady <= (random_pixels >= 250 && steady_pixels < 200);
            w = ($urandom_range(7) == 0) ? 1 : $urandom_range(16, 1);
            h = ($urandom_range(15) == 0) ? 0 : $urandom_range(8, 1);
            nframes = $urandom_range(3, 1);
            run_frames(emii_pkg::CFG_W'(w), emii_pkg::CFG_W'(h), nframes);
            n = nframes * eff_dim(emii_pkg::CFG_W'(w), MAX_W)
                * eff_dim(emii_pkg::CFG_W'(h), MAX_H);
            if (random_pixels >= 250 && steady_pixels < 200)
                steady_pixels += n;
            random_pixels += n;
        end
        steady <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d pixels over %0d complete frames with %0d register writes,",
                 pixels_accepted, frames_seen, reg_writes);
        $display("including mid-frame resizing and saturated widths and heights; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && expected_totals.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
